### design/ehp_pkg.sv
// Shared types, codes and helpers for the EBML element header parser.
package ehp_pkg;

  localparam int unsigned IdW   = 29;
  localparam int unsigned SizeW = 56;
  localparam int unsigned ByteW = 8;
  // tdata: element_id, element_size, payload_byte, then zero fill to whole bytes
  localparam int unsigned OutDataW = ((IdW + SizeW + ByteW + 7) / 8) * 8;
  localparam int unsigned QueueDepth = 2;

  localparam logic [ByteW-1:0] IdMin   = 8'h10;
  localparam logic [ByteW-1:0] TopMark = 8'h80;

  typedef enum logic [1:0] {
    KIND_HDR      = 2'd0,
    KIND_PAYLOAD  = 2'd1,
    KIND_BAD_ID   = 2'd2,
    KIND_BAD_SIZE = 2'd3
  } kind_t;

  // What the back end does with an item from the queue.
  typedef enum logic [2:0] {
    OP_SKIP     = 3'd0,
    OP_ID_FIRST = 3'd1,
    OP_ID_NEXT  = 3'd2,
    OP_HDR      = 3'd3,
    OP_PAYLOAD  = 3'd4,
    OP_BAD_ID   = 3'd5,
    OP_BAD_SIZE = 3'd6
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             last;
    logic [ByteW-1:0] data;
    logic [SizeW-1:0] size;
  } entry_t;

  // Count of zero bits above the highest set bit (byte assumed nonzero).
  function automatic logic [2:0] lead_zeros(input logic [ByteW-1:0] b);
    logic [2:0] n;
    n = '0;
    for (int i = 0; i < ByteW; i++) begin
      if (b[i]) n = 3'(ByteW - 1 - i);
    end
    return n;
  endfunction

endpackage

### design/ehp_front.sv
// Front end: tracks the element layout and tags every accepted byte with an op.
module ehp_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [ehp_pkg::ByteW-1:0]  in_byte,
  output ehp_pkg::entry_t            push_entry
);
  import ehp_pkg::*;

  typedef enum logic [3:0] {
    PH_ID0  = 4'b0001,
    PH_ID   = 4'b0010,
    PH_SIZE = 4'b0100,
    PH_PAY  = 4'b1000
  } phase_t;

  phase_t           phase, phase_next;
  logic [1:0]       id_left, id_left_next;
  logic [2:0]       size_left, size_left_next;
  logic [SizeW-1:0] size_acc, size_acc_next;
  logic [SizeW-1:0] payload_left, payload_left_next;

  logic [2:0]       lz;
  logic [ByteW-1:0] first_size;
  logic [SizeW-1:0] shifted_size;
  logic [SizeW-1:0] pay_dec;

  assign lz           = lead_zeros(in_byte);
  assign first_size   = in_byte & ~(TopMark >> lz);
  assign shifted_size = {size_acc[SizeW-ByteW-1:0], in_byte};
  assign pay_dec      = payload_left - SizeW'(1);

  always_comb begin
    phase_next        = phase;
    id_left_next      = id_left;
    size_left_next    = size_left;
    size_acc_next     = size_acc;
    payload_left_next = payload_left;
    push_entry.op     = OP_SKIP;
    push_entry.last   = 1'b0;
    push_entry.data   = in_byte;
    push_entry.size   = '0;
    case (phase)
      PH_ID0: begin
        if (in_byte < IdMin) begin
          push_entry.op = OP_BAD_ID;
        end else begin
          push_entry.op = OP_ID_FIRST;
          id_left_next  = lz[1:0];
          phase_next    = PH_ID;
        end
      end
      PH_ID: begin
        if (id_left != 2'd0) begin
          push_entry.op = OP_ID_NEXT;
          id_left_next  = id_left - 2'd1;
        end else if (in_byte == '0) begin
          push_entry.op = OP_BAD_SIZE;
          phase_next    = PH_ID0;
        end else if (lz == 3'd0) begin
          // single-byte size: header is complete now
          push_entry.op     = OP_HDR;
          push_entry.size   = SizeW'(first_size);
          payload_left_next = SizeW'(first_size);
          phase_next        = (first_size != '0) ? PH_PAY : PH_ID0;
        end else begin
          size_acc_next  = SizeW'(first_size);
          size_left_next = lz;
          phase_next     = PH_SIZE;
        end
      end
      PH_SIZE: begin
        size_acc_next  = shifted_size;
        size_left_next = size_left - 3'd1;
        if (size_left == 3'd1) begin
          push_entry.op     = OP_HDR;
          push_entry.size   = shifted_size;
          payload_left_next = shifted_size;
          phase_next        = (shifted_size != '0) ? PH_PAY : PH_ID0;
        end
      end
      PH_PAY: begin
        push_entry.op     = OP_PAYLOAD;
        push_entry.last   = (pay_dec == '0);
        payload_left_next = pay_dec;
        if (pay_dec == '0) phase_next = PH_ID0;
      end
      default: begin
        phase_next = PH_ID0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_ID0;
      id_left      <= '0;
      size_left    <= '0;
      payload_left <= '0;
    end else if (in_valid && in_ready) begin
      phase        <= phase_next;
      id_left      <= id_left_next;
      size_left    <= size_left_next;
      payload_left <= payload_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) size_acc <= size_acc_next;
  end

endmodule

### design/ehp_queue.sv
// Two-entry queue between the front end and the back end.
module ehp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ehp_pkg::entry_t push_entry,
  output logic            not_full,
  input  logic            pop,
  output logic            not_empty,
  output ehp_pkg::entry_t head
);
  import ehp_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  entry_t          slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [PtrW:0]   count;
  logic            do_push, do_pop;

  assign not_full  = (count != (PtrW+1)'(QueueDepth));
  assign not_empty = (count != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (PtrW+1)'(1);
        2'b01:   count <= count - (PtrW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

endmodule

### design/ehp_back.sv
// Back end: builds the element ID and forms result items in the output register.
module ehp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  ehp_pkg::entry_t               q_head,
  output logic                          q_pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ehp_pkg::OutDataW-1:0]  m_tdata,
  output logic [1:0]                    m_tuser,
  output logic                          m_tlast
);
  import ehp_pkg::*;

  logic [IdW-1:0] id_accum;
  logic           out_free;
  logic           has_result;
  logic [OutDataW-1:0] data_next;
  kind_t          kind_next;

  assign out_free = !m_tvalid || m_tready;
  assign q_pop    = q_valid && out_free;

  always_comb begin
    has_result = 1'b1;
    data_next  = '0;
    kind_next  = KIND_HDR;
    case (q_head.op)
      OP_HDR: begin
        data_next[IdW-1:0]         = id_accum;
        data_next[IdW+SizeW-1:IdW] = q_head.size;
      end
      OP_PAYLOAD: begin
        kind_next = KIND_PAYLOAD;
        data_next[IdW+SizeW+ByteW-1:IdW+SizeW] = q_head.data;
      end
      OP_BAD_ID:   kind_next = KIND_BAD_ID;
      OP_BAD_SIZE: kind_next = KIND_BAD_SIZE;
      default:     has_result = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      case (q_head.op)
        OP_ID_FIRST: id_accum <= IdW'(q_head.data);
        OP_ID_NEXT:  id_accum <= {id_accum[IdW-ByteW-1:0], q_head.data};
        default:     id_accum <= id_accum;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= q_valid && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && has_result) begin
      m_tdata <= data_next;
      m_tuser <= kind_next;
      m_tlast <= q_head.last;
    end
  end

endmodule

### design/ebml_element_header_parser.sv
// EBML element header parser top level: one stream byte in, at most one result item out.
// Takes one EBML byte per clock and walks a flat run of sibling elements: a 1-4 byte ID
// (marker bits kept, first byte below 0x10 gives an invalid-ID item), a 1-8 byte size
// (marker cleared, zero first byte gives an invalid-size item), then each payload byte
// passed through with tlast on the final one. The header item comes out on the last size
// byte. Sustained rate is one byte per cycle while the queue has room; a byte's result is
// written into the two-entry queue when the byte is accepted, and the back end then moves
// it from the queue into the output register. Input stalls only once the queue fills
// behind a stalled output.
module ebml_element_header_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] in_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ehp_pkg::OutDataW-1:0]  m_tdata,   // [28:0] element_id, [84:29] element_size,
                                                   // [92:85] payload_byte, [95:93] zero
  output logic [1:0]                    m_tuser,   // [1:0] kind
  output logic                          m_tlast    // last_payload
);
  import ehp_pkg::*;

  entry_t push_entry;
  entry_t q_head;
  logic   q_valid;
  logic   q_pop;

  ehp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .push_entry (push_entry)
  );

  ehp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s_tvalid),
    .push_entry (push_entry),
    .not_full   (s_tready),
    .pop        (q_pop),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  ehp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

### design/ehp_checker.sv
// Port-level checks for the EBML element header parser, bound to the top level.
module ehp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ehp_pkg::OutDataW-1:0]  m_tdata,
  input logic [1:0]                    m_tuser,
  input logic                          m_tlast
);
  import ehp_pkg::*;

  localparam int unsigned HdrW = IdW + SizeW;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result item changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // only payload items carry a byte or tlast; everything else leaves them zero
  a_hdr_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_PAYLOAD |->
      m_tdata[OutDataW-1:HdrW] == '0 && !m_tlast)
    else $error("non-payload item carries payload fields");

  a_non_hdr_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_HDR |-> m_tdata[HdrW-1:0] == '0)
    else $error("non-header item carries id or size");

endmodule

bind ebml_element_header_parser ehp_checker u_ehp_checker (.*);

### tb/ebml_header_checker.sv
// Checker for the EBML element header parser: models the byte walk and compares result items.
module ebml_header_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [7:0]                    s_tdata,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [ehp_pkg::OutDataW-1:0]  m_tdata,
  input  logic [1:0]                    m_tuser,
  input  logic                          m_tlast,
  output int unsigned                   fails,
  output int unsigned                   pending
);
  import ehp_pkg::*;

  localparam int unsigned FillW = OutDataW - IdW - SizeW - ByteW;

  typedef struct packed {
    kind_t            kind;
    logic [IdW-1:0]   id;
    logic [SizeW-1:0] size;
    logic [ByteW-1:0] pbyte;
    logic             last;
    logic [FillW-1:0] fill;
  } parse_item_t;

  typedef enum logic [3:0] {
    ST_ID_FIRST  = 4'b0001,
    ST_ID_MORE   = 4'b0010,   // ID continuation, then the first size byte
    ST_SIZE_MORE = 4'b0100,
    ST_PAYLOAD   = 4'b1000
  } walk_t;

  walk_t            walk;
  logic [IdW-1:0]   id_acc;
  logic [1:0]       id_left;
  logic [SizeW-1:0] size_acc;
  logic [2:0]       size_left;
  logic [SizeW-1:0] pay_left;

  parse_item_t parse_results_q [$];

  task automatic parse_byte(input logic [7:0] b, output bit got, output parse_item_t r);
    logic [7:0] mask;
    int         extra;
    bit         hdr_done;
    got      = 1'b0;
    hdr_done = 1'b0;
    r        = '0;
    case (walk)
      ST_ID_FIRST: begin
        if (b < IdMin) begin
          got    = 1'b1;
          r.kind = KIND_BAD_ID;
        end else begin
          mask  = TopMark;
          extra = 0;
          while (mask > IdMin && (b & mask) == 8'd0) begin
            extra++;
            mask = mask >> 1;
          end
          id_acc  = IdW'(b);
          id_left = 2'(extra);
          walk    = ST_ID_MORE;
        end
      end
      ST_ID_MORE: begin
        if (id_left != 2'd0) begin
          id_acc  = {id_acc[IdW-9:0], b};
          id_left = id_left - 2'd1;
        end else if (b == 8'd0) begin
          walk   = ST_ID_FIRST;
          got    = 1'b1;
          r.kind = KIND_BAD_SIZE;
        end else begin
          mask  = TopMark;
          extra = 0;
          while ((b & mask) == 8'd0) begin
            extra++;
            mask = mask >> 1;
          end
          size_acc  = SizeW'(b & ~mask);
          size_left = 3'(extra);
          if (size_left == 3'd0) hdr_done = 1'b1;
          else walk = ST_SIZE_MORE;
        end
      end
      ST_SIZE_MORE: begin
        size_acc  = {size_acc[SizeW-9:0], b};
        size_left = size_left - 3'd1;
        if (size_left == 3'd0) hdr_done = 1'b1;
      end
      default: begin
        pay_left = pay_left - SizeW'(1);
        got      = 1'b1;
        r.kind   = KIND_PAYLOAD;
        r.pbyte  = b;
        r.last   = (pay_left == '0);
        if (pay_left == '0) walk = ST_ID_FIRST;
      end
    endcase
    if (hdr_done) begin
      pay_left = size_acc;
      walk     = (size_acc != '0) ? ST_PAYLOAD : ST_ID_FIRST;
      got      = 1'b1;
      r.kind   = KIND_HDR;
      r.id     = id_acc;
      r.size   = size_acc;
    end
  endtask

  always @(posedge clk) begin
    parse_item_t seen;
    parse_item_t want;
    parse_item_t made;
    bit          got;
    if (rst) begin
      walk      = ST_ID_FIRST;
      id_acc    = '0;
      id_left   = '0;
      size_acc  = '0;
      size_left = '0;
      pay_left  = '0;
      parse_results_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen.kind  = kind_t'(m_tuser);
        seen.id    = m_tdata[IdW-1:0];
        seen.size  = m_tdata[IdW +: SizeW];
        seen.pbyte = m_tdata[IdW+SizeW +: ByteW];
        seen.last  = m_tlast;
        seen.fill  = m_tdata[OutDataW-1 -: FillW];
        if (parse_results_q.size() == 0) begin
          $display("%0t: unexpected item kind %0d id %h size %h byte %h last %0d",
                   $time, seen.kind, seen.id, seen.size, seen.pbyte, seen.last);
          fails++;
        end else begin
          want = parse_results_q.pop_front();
          if (seen !== want) begin
            $display("%0t: expected kind %0d id %h size %h byte %h last %0d fill %h",
                     $time, want.kind, want.id, want.size, want.pbyte, want.last, want.fill);
            $display("%0t:   actual kind %0d id %h size %h byte %h last %0d fill %h",
                     $time, seen.kind, seen.id, seen.size, seen.pbyte, seen.last, seen.fill);
            fails++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        parse_byte(s_tdata, got, made);
        if (got) parse_results_q.push_back(made);
      end
    end
    pending = parse_results_q.size();
  end

endmodule

### tb/tb_ebml_element_header_parser.sv
// Testbench top for the EBML element header parser: byte stimulus, output stalls and verdict.
module tb_ebml_element_header_parser;
  import ehp_pkg::*;

  localparam int unsigned HoldCycles = 200;
  localparam int unsigned RandBytes  = 1120;

  logic                clk;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata  = 8'd0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic [1:0]          m_tuser;
  logic                m_tlast;

  int unsigned fails;
  int unsigned pending;
  int unsigned bytes_sent = 0;
  bit          calm       = 1'b0;
  bit          hold_req   = 1'b0;

  ebml_element_header_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  ebml_header_checker u_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .fails    (fails),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("ebml_element_header_parser: mismatch");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 6);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(99) < 6) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= b;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // ID with its marker at the position that gives len bytes, random content.
  task automatic send_id(input int len);
    logic [7:0] mark;
    mark = 8'h80 >> (len - 1);
    send_byte(mark | (8'($urandom) & (mark - 8'd1)));
    repeat (len - 1) send_byte(8'($urandom));
  endtask

  task automatic send_size(input int len, input logic [55:0] val);
    logic [7:0] mark;
    mark = 8'h80 >> (len - 1);
    send_byte(mark | (8'(val >> (8 * (len - 1))) & (mark - 8'd1)));
    for (int i = len - 2; i >= 0; i--) send_byte(8'(val >> (8 * i)));
  endtask

  initial begin
    logic [7:0]  dir_q [$];
    logic [55:0] big;
    int          roll;
    int          sz;
    bit          did_hold;
    bit          did_pause;
    did_hold  = 1'b0;
    did_pause = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bad IDs, empty element, 1- and 4-byte extremes, bad size, 3-byte ID, then 1-byte all-ones size
    dir_q = '{8'h00, 8'h0F,
              8'h80, 8'h80,
              8'hFF, 8'h81, 8'hFF,
              8'h1F, 8'hFF, 8'hFF, 8'hFF,
              8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'hA5,
              8'h40, 8'h00, 8'h00,
              8'h20, 8'h12, 8'h34, 8'h40, 8'h03, 8'h11, 8'h22, 8'h33,
              8'h10, 8'h00, 8'h00, 8'h00, 8'hFF};
    foreach (dir_q[i]) send_byte(dir_q[i]);
    repeat (127) send_byte(8'($urandom));

    bytes_sent = 0;
    while (bytes_sent < RandBytes) begin
      calm = (bytes_sent >= 800 && bytes_sent < 1000);
      if (!did_hold && bytes_sent >= 400) begin
        did_hold = 1'b1;
        hold_req = 1'b1;
        send_id(2);
        send_size(1, 56'd60);
        repeat (60) send_byte(8'($urandom));
      end else if (!did_pause && bytes_sent >= 700) begin
        did_pause = 1'b1;
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end else begin
        roll = $urandom_range(99);
        if (roll < 6) begin
          send_byte(8'($urandom_range(15)));
        end else if (roll < 10) begin
          send_id($urandom_range(1, 4));
          send_byte(8'h00);
        end else begin
          roll = $urandom_range(99);
          if (roll < 25) sz = 0;
          else if (roll < 85) sz = $urandom_range(1, 8);
          else sz = $urandom_range(9, 64);
          send_id($urandom_range(1, 4));
          send_size($urandom_range(1) ? 1 : $urandom_range(1, 8), 56'(sz));
          repeat (sz) send_byte(8'($urandom));
        end
      end
    end
    calm = 1'b0;

    // widest size last: its payload never finishes, so only a few bytes follow
    big = $urandom_range(1) ? '1 : {24'($urandom), 32'($urandom)};
    send_id(4);
    send_size(8, big);
    repeat (5) send_byte(8'($urandom));

    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("ebml_element_header_parser: match");
    end else begin
      $display("ebml_element_header_parser: mismatch");
    end
    $finish;
  end

endmodule

### files.f
design/ehp_pkg.sv
design/ehp_front.sv
design/ehp_queue.sv
design/ehp_back.sv
design/ebml_element_header_parser.sv
design/ehp_checker.sv
tb/ebml_header_checker.sv
tb/tb_ebml_element_header_parser.sv
